### rtl/ptw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and codes for the page table walker.
// Holds the request and response payload structs and the status codes.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int ADDR_W = 48;
  localparam int FLAG_W = 12;
  localparam int LEVEL_BITS = 9;
  localparam int ENTRY_W = 64;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_MAP   = 2'd2,
    KIND_XLATE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_LEAF_FLAGS  = 2'd1,
    REG_TABLE_FLAGS = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        space;
    logic [ADDR_W-1:0] vaddr;
    logic [ADDR_W-1:0] paddr;
    logic              may_allocate;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_addr;
    logic [2:0]        tables_added;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/page_table_walker_with_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_walker_with_allocator: page pool and four-level table walker.
// Allocates, frees, maps and translates pages under one small sequencer.
// ----------------------------------------------------------------------------
// One request is taken at a time and its response sits in an output register
// until transferred. The free-page scan reads one in-use bit per cycle, and an
// allocated page is then zeroed one table entry per cycle through the single
// store port. A table level read steps through address, registered data and
// check states. A map that adds tables does one scan and one zeroing pass per
// table added, plus one link write for each table below the root.
// There is no clearing pass after reset: pages are zeroed when allocated.
module page_table_walker_with_allocator
  import ptw_pkg::*;
#(
  parameter int NUM_PAGES = 64,
  parameter int NUM_SPACES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire req_t        in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      rsp_t        out_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int SLOT_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SCAN_W = $clog2(NUM_PAGES + 1);
  localparam int SP_W = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
  localparam int POS_W = SLOT_W + LEVEL_BITS;
  localparam int DEPTH = NUM_PAGES * 512;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ZERO, S_WALK, S_RDWAIT, S_CHECK, S_LEAF, S_XCHECK, S_DONE
  } state_t;

  // Configuration registers.
  logic [ADDR_W-1:0] pool_base;
  logic [FLAG_W-1:0] leaf_flags, table_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= ADDR_W'(48'h400000);
      leaf_flags <= FLAG_W'(12'h743);
      table_flags <= FLAG_W'(12'h3);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POOL_BASE:   pool_base <= cfg_data[ADDR_W-1:0];
        REG_LEAF_FLAGS:  leaf_flags <= cfg_data[FLAG_W-1:0];
        REG_TABLE_FLAGS: table_flags <= cfg_data[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Table store: one port, registered read.
  logic [ENTRY_W-1:0] store [DEPTH];
  logic [POS_W-1:0]   mem_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_addr] <= mem_wdata;
    mem_rdata <= store[mem_addr];
  end

  // Sequencer state.
  state_t             state;
  req_t               req;
  logic [NUM_PAGES-1:0]  in_use;
  logic [NUM_SPACES-1:0] root_valid;
  logic [SLOT_W-1:0]  root_slot [NUM_SPACES];
  logic [SCAN_W-1:0]  scan;
  logic [LEVEL_BITS:0] zcnt;
  logic [SLOT_W-1:0]  slot, new_slot;
  logic [1:0]         lvl;
  logic               root_pending;
  logic [2:0]         added;
  logic [SP_W-1:0]    sp;

  // Pool address arithmetic: the shared offset subtract.
  logic [ADDR_W-1:0] off_in, off;
  logic              in_pool;
  assign off = off_in - pool_base;
  assign in_pool = (off[ADDR_W-1:12] < (ADDR_W-12)'(NUM_PAGES));

  logic [LEVEL_BITS-1:0] idx;
  always_comb begin
    case (lvl)
      2'd0: idx = req.vaddr[47:39];
      2'd1: idx = req.vaddr[38:30];
      2'd2: idx = req.vaddr[29:21];
      default: idx = req.vaddr[20:12];
    endcase
  end

  logic [ADDR_W-1:0] new_addr;
  assign new_addr = pool_base + {{(ADDR_W-SLOT_W-12){1'b0}}, new_slot, 12'h000};

  // Link written in the cycle after a table page was zeroed.
  logic link_pending;
  logic [ENTRY_W-1:0] link_word;
  assign link_word = {16'h0, new_addr} | {{(ENTRY_W-FLAG_W){1'b0}}, table_flags};

  assign sp = req.space[SP_W-1:0];
  assign in_stall = (state != S_IDLE) || out_valid;

  // Store port: zeroing, table links and leaf writes share the one port.
  always_comb begin
    off_in = (state == S_IDLE) ? in_data.paddr : {mem_rdata[ADDR_W-1:12], 12'h000};
    mem_addr = {slot, idx};
    mem_we = 1'b0;
    mem_wdata = '0;
    if (state == S_ZERO) begin
      mem_addr = {new_slot, zcnt[LEVEL_BITS-1:0]};
      mem_we = 1'b1;
    end else if (state == S_WALK && link_pending) begin
      mem_we = 1'b1;
      mem_wdata = link_word;
    end else if (state == S_LEAF) begin
      mem_we = (req.kind == KIND_MAP);
      mem_wdata = {16'h0, req.paddr[ADDR_W-1:12], 12'h000};
      mem_wdata[FLAG_W-1:0] = leaf_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      in_use <= '0;
      root_valid <= '0;
      link_pending <= 1'b0;
      root_pending <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req <= in_data;
            added <= '0;
            lvl <= '0;
            scan <= '0;
            zcnt <= '0;
            link_pending <= 1'b0;
            root_pending <= 1'b0;
            case (kind_t'(in_data.kind))
              KIND_ALLOC: state <= S_SCAN;
              KIND_FREE: begin
                out_data.tables_added <= '0;
                out_data.result_addr <= '0;
                if (in_pool) begin
                  in_use[off[12+SLOT_W-1:12]] <= 1'b0;
                  out_data.status <= ST_OK;
                end else out_data.status <= ST_OUTSIDE;
                out_valid <= 1'b1;
              end
              default: begin
                if (32'(in_data.space) >= NUM_SPACES) begin
                  out_data <= '{status: ST_ABSENT, result_addr: '0, tables_added: '0};
                  out_valid <= 1'b1;
                end else if (!root_valid[in_data.space[SP_W-1:0]]) begin
                  if (in_data.kind == KIND_MAP && in_data.may_allocate) begin
                    root_pending <= 1'b1;
                    state <= S_SCAN;
                  end else begin
                    out_data <= '{status: ST_ABSENT, result_addr: '0, tables_added: '0};
                    out_valid <= 1'b1;
                  end
                end else begin
                  slot <= root_slot[in_data.space[SP_W-1:0]];
                  state <= S_WALK;
                end
              end
            endcase
          end
        end
        // First-free scan, one bit per cycle.
        S_SCAN: begin
          if (scan == SCAN_W'(NUM_PAGES)) begin
            out_data <= '{status: ST_EXHAUSTED, result_addr: '0, tables_added: added};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (!in_use[scan[SLOT_W-1:0]]) begin
            in_use[scan[SLOT_W-1:0]] <= 1'b1;
            new_slot <= scan[SLOT_W-1:0];
            zcnt <= '0;
            state <= S_ZERO;
          end else scan <= scan + 1'b1;
        end
        // Zero the new page, one entry per cycle.
        S_ZERO: begin
          zcnt <= zcnt + 1'b1;
          if (zcnt == (LEVEL_BITS+1)'(511)) begin
            if (req.kind == KIND_ALLOC) begin
              out_data <= '{status: ST_OK, result_addr: new_addr, tables_added: '0};
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              added <= added + 1'b1;
              if (root_pending) begin
                root_pending <= 1'b0;
                root_valid[sp] <= 1'b1;
                root_slot[sp] <= new_slot;
                slot <= new_slot;
              end else link_pending <= 1'b1;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (link_pending) begin
            link_pending <= 1'b0;
            slot <= new_slot;
            lvl <= lvl + 1'b1;
            state <= (lvl == 2'd2) ? S_LEAF : S_WALK;
          end else state <= (lvl == 2'd3) ? S_LEAF : S_RDWAIT;
        end
        S_RDWAIT: state <= S_CHECK;
        S_CHECK: begin
          if (mem_rdata == '0) begin
            if (req.kind == KIND_MAP && req.may_allocate) begin
              scan <= '0;
              state <= S_SCAN;
            end else begin
              out_data <= '{status: ST_ABSENT, result_addr: '0, tables_added: added};
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else if (!in_pool) begin
            out_data <= '{status: ST_OUTSIDE, result_addr: '0, tables_added: added};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            slot <= off[12+SLOT_W-1:12];
            lvl <= lvl + 1'b1;
            state <= (lvl == 2'd2) ? S_LEAF : S_WALK;
          end
        end
        S_LEAF: begin
          if (req.kind == KIND_MAP) begin
            out_data <= '{status: ST_OK, result_addr: '0, tables_added: added};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else state <= S_XCHECK;
        end
        S_XCHECK: state <= S_DONE;
        S_DONE: begin
          if (mem_rdata[FLAG_W-1:0] != leaf_flags)
            out_data <= '{status: ST_ABSENT, result_addr: '0, tables_added: '0};
          else
            out_data <= '{status: ST_OK, result_addr: {mem_rdata[ADDR_W-1:12], 12'h000},
                          tables_added: '0};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Assertions.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("response dropped under stall");
  a_added_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.tables_added <= 3'd4)) else $error("too many tables");
  a_ok_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> (out_data.result_addr == '0))
    else $error("address on error");

endmodule
`default_nettype wire
